FILE: sv/qmn_pkg.sv
// Shared types and widths for the normalized quaternion product core.
// No dependencies; imported by every module of the block.
package qmn_pkg;

    localparam int COMP_W    = 16;
    localparam int FRAC_BITS = COMP_W - 2;
    localparam int PRE_SHIFT = (COMP_W > 30) ? 2 : 0;
    localparam int PROD_W    = 2 * COMP_W - PRE_SHIFT;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = SUM_W;
    localparam int LEN_W     = $clog2(MAG_W + 1);
    localparam int NORM_BITS = 30;
    localparam int SQ_W      = 2 * NORM_BITS;
    localparam int Q_W       = SQ_W + 2;
    localparam int RB        = NORM_BITS + 1;
    localparam int QB        = FRAC_BITS + 2;
    localparam int NUM_W     = NORM_BITS + FRAC_BITS + 1;
    localparam int DIV_W     = RB + QB;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] b_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
    } t_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_w;
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     zero_magnitude;
    } t_out;

    // raw Hamilton product handed from front to back
    typedef struct packed {
        logic [3:0][SUM_W-1:0] p;
        logic                  zero;
    } t_prod;

endpackage

FILE: sv/qmn_front.sv
// Front end: accepts operand pairs, forms the 16 partial products and the
// four Hamilton sums. Depends on qmn_pkg.
module qmn_front
    import qmn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_in   i_a,
    output logic  o_q_push,
    output t_prod o_q_data,
    input  logic  i_q_full
);

    logic signed [COMP_W-1:0]   opa [16];
    logic signed [COMP_W-1:0]   opb [16];
    logic signed [2*COMP_W-1:0] full_pr [16];
    logic signed [2*COMP_W-1:0] sh_pr [16];
    logic signed [PROD_W-1:0]   n_pp [16];
    logic signed [PROD_W-1:0]   r_pp [16];
    logic signed [SUM_W-1:0]    n_s [4];
    logic                       r_v1, r_v2;
    t_prod                      r_out;
    logic                       en;

    assign en       = !(r_v2 && i_q_full);
    assign full     = !en;
    assign o_q_push = r_v2 && en;
    assign o_q_data = r_out;

    always_comb begin
        // ww xx yy zz | aw.bx bw.ax ay.bz az.by | aw.by bw.ay az.bx ax.bz
        // | aw.bz bw.az ax.by ay.bx
        opa[0]  = i_a.a_w; opb[0]  = i_a.b_w;
        opa[1]  = i_a.a_x; opb[1]  = i_a.b_x;
        opa[2]  = i_a.a_y; opb[2]  = i_a.b_y;
        opa[3]  = i_a.a_z; opb[3]  = i_a.b_z;
        opa[4]  = i_a.a_w; opb[4]  = i_a.b_x;
        opa[5]  = i_a.b_w; opb[5]  = i_a.a_x;
        opa[6]  = i_a.a_y; opb[6]  = i_a.b_z;
        opa[7]  = i_a.a_z; opb[7]  = i_a.b_y;
        opa[8]  = i_a.a_w; opb[8]  = i_a.b_y;
        opa[9]  = i_a.b_w; opb[9]  = i_a.a_y;
        opa[10] = i_a.a_z; opb[10] = i_a.b_x;
        opa[11] = i_a.a_x; opb[11] = i_a.b_z;
        opa[12] = i_a.a_w; opb[12] = i_a.b_z;
        opa[13] = i_a.b_w; opb[13] = i_a.a_z;
        opa[14] = i_a.a_x; opb[14] = i_a.b_y;
        opa[15] = i_a.a_y; opb[15] = i_a.b_x;
        for (int i = 0; i < 16; i++) begin
            full_pr[i] = opa[i] * opb[i];
            sh_pr[i]   = full_pr[i] >>> PRE_SHIFT;   // floor shift
            n_pp[i]    = sh_pr[i][PROD_W-1:0];
        end
    end

    always_comb begin
        n_s[0] = SUM_W'(r_pp[0]) - SUM_W'(r_pp[1]) - SUM_W'(r_pp[2]) - SUM_W'(r_pp[3]);
        n_s[1] = SUM_W'(r_pp[4]) + SUM_W'(r_pp[5]) + SUM_W'(r_pp[6]) - SUM_W'(r_pp[7]);
        n_s[2] = SUM_W'(r_pp[8]) + SUM_W'(r_pp[9]) + SUM_W'(r_pp[10]) - SUM_W'(r_pp[11]);
        n_s[3] = SUM_W'(r_pp[12]) + SUM_W'(r_pp[13]) + SUM_W'(r_pp[14]) - SUM_W'(r_pp[15]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp <= n_pp;
            for (int i = 0; i < 4; i++) begin
                r_out.p[i] <= n_s[i];
            end
            r_out.zero <= (n_s[0] == '0) && (n_s[1] == '0) &&
                          (n_s[2] == '0) && (n_s[3] == '0);
        end
    end

endmodule

FILE: sv/qmn_queue.sv
// Short queue between front and back ends.
// Depends on qmn_pkg.
module qmn_queue
    import qmn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_prod i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_prod o_data,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_prod             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [PTR_W:0]    r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: sv/qmn_back.sv
// Back end: magnitude scaling, squared norm, pipelined square root,
// pipelined restoring division, saturation, 2-entry output buffer.
// Depends on qmn_pkg.
module qmn_back
    import qmn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_empty,
    input  t_prod i_q_data,
    output logic  o_q_pop,
    output logic  empty,
    input  logic  pop,
    output t_out  o_res
);

    typedef struct packed {
        logic                   vld;
        logic                   zero;
        logic [3:0]             neg;
        logic [3:0][MAG_W-1:0]  mag;
        logic [MAG_W-1:0]       maxm;
        logic [LEN_W-1:0]       len;
        logic [3:0][NORM_BITS-1:0] m;
        logic [3:0][SQ_W-1:0]   sq;
        logic [Q_W-1:0]         qv;
        logic [Q_W-1:0]         res;
        logic [3:0][DIV_W-1:0]  rem;
        logic [3:0][QB-1:0]     quo;
    } t_bk;

    localparam logic [QB-1:0] ONE = QB'(1) << FRAC_BITS;

    logic en;
    t_bk  r_s0, r_s1, r_s2, r_s3, r_s4;
    t_bk  n_s0, n_s1, n_s2, n_s3, n_s4;
    t_bk  r_sqp [RB+1];
    t_bk  n_sqp [RB+1];
    t_bk  r_dvp [QB+1];
    t_bk  n_dvp [QB+1];
    t_out fin;
    t_out r_ob [2];
    logic [1:0] r_cnt;
    logic ob_push, ob_pop, wr_idx;

    assign en      = (r_cnt != 2'd2);
    assign o_q_pop = en && !i_q_empty;

    // sign and magnitude
    always_comb begin
        n_s0      = '0;
        n_s0.vld  = o_q_pop;
        n_s0.zero = i_q_data.zero;
        for (int i = 0; i < 4; i++) begin
            n_s0.neg[i] = i_q_data.p[i][SUM_W-1];
            n_s0.mag[i] = n_s0.neg[i] ? MAG_W'(-i_q_data.p[i]) : MAG_W'(i_q_data.p[i]);
        end
    end

    // largest magnitude
    always_comb begin
        logic [MAG_W-1:0] m01, m23;
        n_s1      = r_s0;
        m01       = (r_s0.mag[0] > r_s0.mag[1]) ? r_s0.mag[0] : r_s0.mag[1];
        m23       = (r_s0.mag[2] > r_s0.mag[3]) ? r_s0.mag[2] : r_s0.mag[3];
        n_s1.maxm = (m01 > m23) ? m01 : m23;
    end

    // bit length of the largest magnitude
    always_comb begin
        n_s2     = r_s1;
        n_s2.len = '0;
        for (int j = 0; j < MAG_W; j++) begin
            if (r_s1.maxm[j]) n_s2.len = LEN_W'(j + 1);
        end
    end

    // common power-of-two scaling to NORM_BITS
    always_comb begin
        logic [MAG_W+NORM_BITS-1:0] t;
        n_s3 = r_s2;
        for (int i = 0; i < 4; i++) begin
            if (r_s2.len > LEN_W'(NORM_BITS)) begin
                t = (MAG_W+NORM_BITS)'(r_s2.mag[i]) >> (r_s2.len - LEN_W'(NORM_BITS));
            end else begin
                t = (MAG_W+NORM_BITS)'(r_s2.mag[i]) << (LEN_W'(NORM_BITS) - r_s2.len);
            end
            n_s3.m[i] = t[NORM_BITS-1:0];
        end
    end

    // squares
    always_comb begin
        n_s4 = r_s3;
        for (int i = 0; i < 4; i++) begin
            n_s4.sq[i] = SQ_W'(r_s3.m[i]) * SQ_W'(r_s3.m[i]);
        end
    end

    // sum of squares
    always_comb begin
        n_sqp[0]     = r_s4;
        n_sqp[0].qv  = Q_W'(r_s4.sq[0]) + Q_W'(r_s4.sq[1]) +
                       Q_W'(r_s4.sq[2]) + Q_W'(r_s4.sq[3]);
        n_sqp[0].res = '0;
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        localparam logic [Q_W-1:0] BIT = Q_W'(1) << (2 * (RB - 1 - k));
        always_comb begin
            logic [Q_W-1:0] t;
            n_sqp[k+1] = r_sqp[k];
            t = r_sqp[k].res + BIT;
            if (r_sqp[k].qv >= t) begin
                n_sqp[k+1].qv  = r_sqp[k].qv - t;
                n_sqp[k+1].res = (r_sqp[k].res >> 1) + BIT;
            end else begin
                n_sqp[k+1].res = r_sqp[k].res >> 1;
            end
        end
    end

    // rounded dividend
    always_comb begin
        logic [NUM_W-1:0] num;
        n_dvp[0] = r_sqp[RB];
        for (int i = 0; i < 4; i++) begin
            num = (NUM_W'(r_sqp[RB].m[i]) << FRAC_BITS) +
                  NUM_W'(r_sqp[RB].res[RB-1:1]);
            n_dvp[0].rem[i] = DIV_W'(num);
            n_dvp[0].quo[i] = '0;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_div
        always_comb begin
            logic [DIV_W-1:0] d;
            n_dvp[k+1] = r_dvp[k];
            d = DIV_W'(r_dvp[k].res[RB-1:0]) << (QB - 1 - k);
            for (int i = 0; i < 4; i++) begin
                if (r_dvp[k].rem[i] >= d) begin
                    n_dvp[k+1].rem[i]            = r_dvp[k].rem[i] - d;
                    n_dvp[k+1].quo[i][QB-1-k]    = 1'b1;
                end
            end
        end
    end

    // saturate, apply sign, force zero for a zero product
    always_comb begin
        logic [QB-1:0]     v [4];
        logic [COMP_W-1:0] o [4];
        for (int i = 0; i < 4; i++) begin
            v[i] = (r_dvp[QB].quo[i] > ONE) ? ONE : r_dvp[QB].quo[i];
            o[i] = r_dvp[QB].neg[i] ? COMP_W'(-v[i]) : COMP_W'(v[i]);
            if (r_dvp[QB].zero) o[i] = '0;
        end
        fin.out_w          = o[0];
        fin.out_x          = o[1];
        fin.out_y          = o[2];
        fin.out_z          = o[3];
        fin.zero_magnitude = r_dvp[QB].zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
            r_s4.vld <= 1'b0;
            for (int k = 0; k <= RB; k++) r_sqp[k].vld <= 1'b0;
            for (int k = 0; k <= QB; k++) r_dvp[k].vld <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            for (int k = 0; k <= RB; k++) r_sqp[k] <= n_sqp[k];
            for (int k = 0; k <= QB; k++) r_dvp[k] <= n_dvp[k];
        end
    end

    // output buffer, head in entry 0
    assign ob_push = r_dvp[QB].vld && en;
    assign ob_pop  = pop && (r_cnt != 2'd0);
    assign wr_idx  = r_cnt[0] ^ ob_pop;
    assign empty   = (r_cnt == 2'd0);
    assign o_res   = r_ob[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(ob_push) - 2'(ob_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push && !wr_idx) begin
            r_ob[0] <= fin;
        end else if (ob_pop) begin
            r_ob[0] <= r_ob[1];
        end
        if (ob_push && wr_idx) r_ob[1] <= fin;
    end

endmodule

FILE: sv/quaternion_multiply_normalize_core.sv
// Top level of the normalized quaternion product core.
// Depends on qmn_pkg, qmn_front, qmn_queue, qmn_back.
// Usage:
//  - Input side is a queue write port: drive i_a (two quaternions, Q2.14)
//    and raise push; the transaction is taken at a clock edge where push
//    is high and full is low.
//  - Result side is a queue read port: while empty is low, o_res holds the
//    oldest result (normalized product, zero_magnitude flag); it is taken
//    at a clock edge where pop is high.
//  - Throughput: one transaction per cycle, sustained, for as long as the
//    receiver pops every cycle. Every stage of multiply, square root and
//    division is its own pipeline register, so nothing is iterated.
//  - Pipeline: from the push edge to the result showing on o_res the path is
//    2 front stages, queue, 5 scaling stages, 32 square root stages,
//    17 division stages and the output buffer.
//  - When the receiver stalls, the 2-entry output buffer fills, the back
//    pipeline freezes, the 4-entry queue absorbs the front's output, and
//    full rises once that queue is full and the front's last stage is valid.
//  - Reset (synchronous, active low) drops all in-flight transactions and
//    leaves the block empty and ready.
module quaternion_multiply_normalize_core
    import qmn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_a,
    output logic empty,
    input  logic pop,
    output t_out o_res
);

    logic  q_push, q_full, q_pop, q_empty;
    t_prod q_wdata, q_rdata;

    qmn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_a      (i_a),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    qmn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    qmn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_res     (o_res)
    );

endmodule
